@@ rtl/dboc_pkg.sv @@
package dboc_pkg;

	localparam int unsigned QUIET_W  = 16;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned HOLD_W   = 24;
	localparam int unsigned GAIN_W   = 8;
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned CFG_W    = 24;
	localparam int unsigned IDX_W    = 2;

	localparam logic [QUIET_W-1:0] QUIET_TOP = {QUIET_W{1'b1}};
	localparam logic [HOLD_W-1:0]  HOLD_TOP  = {HOLD_W{1'b1}};
	localparam logic [7:0]         DRIVE_TOP = 8'hFF;

	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX      = 2'd1;
	localparam logic [IDX_W-1:0] REG_HOLD     = 2'd2;
	localparam logic [IDX_W-1:0] REG_GAIN     = 2'd3;

	localparam logic [QUIET_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [COUNT_W-1:0] MAX_RST      = 8'd6;
	localparam logic [HOLD_W-1:0]  HOLD_RST     = 24'd30000;
	localparam logic [GAIN_W-1:0]  GAIN_RST     = 8'd38;

	typedef struct packed {
		logic [QUIET_W-1:0] debounce_ticks;
		logic [COUNT_W-1:0] max_people;
		logic [HOLD_W-1:0]  hold_ticks;
		logic [GAIN_W-1:0]  gain_q8;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               send;
	} tally_t;

endpackage

@@ rtl/dboc_debounce.sv @@
module dboc_debounce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        level,
	input  logic [dboc_pkg::QUIET_W-1:0] debounce_ticks,
	output logic                        press
);
	import dboc_pkg::*;

	logic               prev_q;
	logic               stable_q;
	logic [QUIET_W-1:0] quiet_q;
	logic [QUIET_W-1:0] quiet_nxt;
	logic               take;

	always_comb begin
		if (level != prev_q) begin
			quiet_nxt = '0;
		end else if (quiet_q != QUIET_TOP) begin
			quiet_nxt = quiet_q + 1'b1;
		end else begin
			quiet_nxt = quiet_q;
		end
		take  = (quiet_nxt > debounce_ticks) && (level != stable_q);
		press = take && !level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b1;
			stable_q <= 1'b0;
			quiet_q  <= '0;
		end else if (en) begin
			prev_q  <= level;
			quiet_q <= quiet_nxt;
			if (take) begin
				stable_q <= level;
			end
		end
	end

endmodule

@@ rtl/dboc_tally.sv @@
module dboc_tally (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            inc_press,
	input  logic            dec_press,
	input  logic            link,
	input  dboc_pkg::cfg_t  cfg,
	output dboc_pkg::tally_t res
);
	import dboc_pkg::*;

	logic [COUNT_W-1:0] occ_q;
	logic               pend_q;
	logic [HOLD_W-1:0]  hold_q;

	logic [COUNT_W:0]   up;
	logic [COUNT_W-1:0] occ_a;
	logic [COUNT_W-1:0] occ_b;
	logic               changed;
	logic               pend_nxt;
	logic [HOLD_W-1:0]  hold_nxt;
	logic               send;

	always_comb begin
		up      = {1'b0, occ_q} + 1'b1;
		occ_a   = occ_q;
		changed = 1'b0;
		if (inc_press) begin
			if (up > {1'b0, cfg.max_people}) begin
				occ_a = cfg.max_people;
			end else begin
				occ_a   = up[COUNT_W-1:0];
				changed = 1'b1;
			end
		end
		occ_b = occ_a;
		if (dec_press && occ_a != '0) begin
			occ_b   = occ_a - 1'b1;
			changed = 1'b1;
		end

		pend_nxt = pend_q;
		hold_nxt = hold_q;
		if (changed) begin
			pend_nxt = 1'b1;
			hold_nxt = '0;
		end else if (pend_q && hold_q != HOLD_TOP) begin
			hold_nxt = hold_q + 1'b1;
		end

		send = 1'b0;
		if (pend_nxt && hold_nxt >= cfg.hold_ticks) begin
			if (link) begin
				pend_nxt = 1'b0;
				send     = 1'b1;
			end else begin
				hold_nxt = '0;
			end
		end

		res.count = occ_b;
		res.send  = send;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			pend_q <= 1'b0;
			hold_q <= '0;
		end else if (en) begin
			occ_q  <= occ_b;
			pend_q <= pend_nxt;
			hold_q <= hold_nxt;
		end
	end

endmodule

@@ rtl/dboc_lamp.sv @@
module dboc_lamp (
	input  logic [dboc_pkg::SAMPLE_W-1:0] sample,
	input  logic [dboc_pkg::GAIN_W-1:0]   gain_q8,
	input  logic [dboc_pkg::COUNT_W-1:0]  count,
	input  logic [dboc_pkg::COUNT_W-1:0]  max_people,
	output logic [7:0]                    vacant,
	output logic [7:0]                    full
);
	import dboc_pkg::*;

	logic [SAMPLE_W+GAIN_W-1:0] product;
	logic [SAMPLE_W-1:0]        scaled;
	logic [7:0]                 drive;

	always_comb begin
		product = {{GAIN_W{1'b0}}, sample} * {{SAMPLE_W{1'b0}}, gain_q8};
		scaled  = product[SAMPLE_W+GAIN_W-1:GAIN_W];
		drive   = (scaled > {2'b00, DRIVE_TOP}) ? DRIVE_TOP : scaled[7:0];
		vacant  = '0;
		full    = '0;
		if (count != '0) begin
			if (count >= max_people) begin
				full = drive;
			end else begin
				vacant = drive;
			end
		end
	end

endmodule

@@ rtl/debounced_occupancy_counter.sv @@
// channel | handshake             | payload
// --------+-----------------------+---------------------------------------------
// in      | in_valid / in_stall   | inc_level, dec_level, bright_sample, link_up
// out     | out_valid / out_stall | people_count, vacant_drive, full_drive,
//         |                       | send_update
// cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One request per cycle while out_stall is low; each request goes through the
// input register, then all debounce, count, report-timer and lamp logic in one
// pass into the result register. The state registers update as a request
// moves from the input register into the result register.
// Reset clears the state and loads the register defaults.
// out_stall holds a full result register and, through it, the input register.
module debounced_occupancy_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          inc_level,
	input  logic                          dec_level,
	input  logic [dboc_pkg::SAMPLE_W-1:0] bright_sample,
	input  logic                          link_up,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dboc_pkg::COUNT_W-1:0]  people_count,
	output logic [7:0]                    vacant_drive,
	output logic [7:0]                    full_drive,
	output logic                          send_update,
	input  logic                          cfg_we,
	input  logic [dboc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dboc_pkg::CFG_W-1:0]    cfg_data
);
	import dboc_pkg::*;

	cfg_t cfg_q;

	logic                valid_s1;
	logic                inc_s1;
	logic                dec_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                link_s1;

	logic                valid_s2;
	logic [COUNT_W-1:0]  count_s2;
	logic [7:0]          vacant_s2;
	logic [7:0]          full_s2;
	logic                send_s2;

	logic                advance;
	logic                fire;
	logic                take_in;
	logic                inc_press;
	logic                dec_press;
	tally_t              tally;
	logic [7:0]          vacant;
	logic [7:0]          full;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.max_people     <= MAX_RST;
			cfg_q.hold_ticks     <= HOLD_RST;
			cfg_q.gain_q8        <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data[QUIET_W-1:0];
				REG_MAX:      cfg_q.max_people     <= cfg_data[COUNT_W-1:0];
				REG_HOLD:     cfg_q.hold_ticks     <= cfg_data[HOLD_W-1:0];
				REG_GAIN:     cfg_q.gain_q8        <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			inc_s1    <= inc_level;
			dec_s1    <= dec_level;
			sample_s1 <= bright_sample;
			link_s1   <= link_up;
		end
	end

	dboc_debounce u_inc (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (fire),
		.level          (inc_s1),
		.debounce_ticks (cfg_q.debounce_ticks),
		.press          (inc_press)
	);

	dboc_debounce u_dec (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (fire),
		.level          (dec_s1),
		.debounce_ticks (cfg_q.debounce_ticks),
		.press          (dec_press)
	);

	dboc_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (fire),
		.inc_press (inc_press),
		.dec_press (dec_press),
		.link      (link_s1),
		.cfg       (cfg_q),
		.res       (tally)
	);

	dboc_lamp u_lamp (
		.sample     (sample_s1),
		.gain_q8    (cfg_q.gain_q8),
		.count      (tally.count),
		.max_people (cfg_q.max_people),
		.vacant     (vacant),
		.full       (full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			count_s2  <= tally.count;
			vacant_s2 <= vacant;
			full_s2   <= full;
			send_s2   <= tally.send;
		end
	end

	assign out_valid    = valid_s2;
	assign people_count = count_s2;
	assign vacant_drive = vacant_s2;
	assign full_drive   = full_s2;
	assign send_update  = send_s2;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a held request");

	a_fire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("request lost between stages");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_stall && !valid_s1) |=> !valid_s2)
		else $error("result repeated after delivery");

	a_one_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(vacant_s2 != '0 && full_s2 != '0))
		else $error("both lamps driven");

endmodule
